>>> rtl/trfp_pkg.sv
// ----------------------------------------------------------------------------
// trfp_pkg
// Types and constants shared by the track report frame parser modules.
// ----------------------------------------------------------------------------
package trfp_pkg;

  // Frame layout, in bytes.
  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned MASK_BYTES  = 4;
  localparam int unsigned POINT_BYTES = 8;

  // Byte offsets of the header fields.
  localparam logic [10:0] OFF_VERSION    = 11'd0;
  localparam logic [10:0] OFF_TIME_LAST  = 11'd4;
  localparam logic [10:0] OFF_INTVL_LAST = 11'd6;
  localparam logic [10:0] OFF_COUNT      = 11'd7;
  localparam logic [10:0] OFF_MASK_END   = 11'd12;
  localparam logic [10:0] OFF_MASK_LAST  = 11'd11;

  // Point counts at or above this value default to an all-ones mask.
  localparam logic [7:0] MASK_FULL_COUNT = 8'd32;

  // Register map.
  localparam logic REG_EXPECTED_VERSION = 1'b0;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SHORT     = 2'd0,
    ERR_VERSION   = 2'd1,
    ERR_COUNT     = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    logic [10:0] byte_offset;
    logic [10:0] frame_bytes;
    logic        skipping;
    logic        mask_present;
    logic [31:0] hdr_start_time;
    logic [15:0] hdr_interval;
    logic [7:0]  hdr_count;
    logic [31:0] hdr_mask;
    logic [7:0]  points_done;
    logic [55:0] point_shift;
  } state_t;

  // One result item.
  typedef struct packed {
    kind_t              kind;
    err_t               error_code;
    logic        [31:0] start_time;
    logic        [15:0] interval_secs;
    logic        [7:0]  point_count;
    logic        [31:0] valid_bits;
    logic        [7:0]  point_index;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic               last;
  } result_t;

endpackage

>>> rtl/trfp_step.sv
// ----------------------------------------------------------------------------
// trfp_step
// Per-byte parser step: from the current state and one frame byte, forms
// the next state and at most one result item.
// ----------------------------------------------------------------------------
module trfp_step #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  trfp_pkg::state_t  st,
  input  logic [7:0]        rx_byte,
  input  logic [10:0]       frame_len,
  input  logic [7:0]        expected_version,
  output trfp_pkg::state_t  st_next,
  output logic              res_valid,
  output trfp_pkg::result_t res
);
  import trfp_pkg::*;

  state_t      cur;
  logic [10:0] off;
  logic [11:0] pbytes;
  logic [11:0] need_mask;
  logic [11:0] need_points;
  logic [11:0] frame_ext;
  logic [10:0] rel;
  logic [2:0]  pos;
  logic [1:0]  time_lane;
  logic [31:0] dflt_mask;
  logic        pt_last;

  // Frame start clears the per-frame state and latches the length.
  always_comb begin
    cur = st;
    if (st.byte_offset == 11'd0) begin
      cur.frame_bytes  = frame_len;
      cur.skipping     = 1'b0;
      cur.mask_present = 1'b0;
      cur.hdr_count    = 8'd0;
      cur.hdr_mask     = 32'd0;
      cur.points_done  = 8'd0;
      cur.point_shift  = 56'd0;
    end
  end

  // Derived quantities for the count byte and the point bytes.
  assign off         = cur.byte_offset;
  assign frame_ext   = {1'b0, cur.frame_bytes};
  assign pbytes      = {1'b0, rx_byte, 3'b000};
  assign need_mask   = 12'(HDR_BYTES + MASK_BYTES) + pbytes;
  assign need_points = 12'(HDR_BYTES) + pbytes;
  assign rel         = off - (cur.mask_present ? OFF_MASK_END : 11'(HDR_BYTES));
  assign pos         = rel[2:0];
  assign time_lane   = 2'(off - 11'd1);
  assign dflt_mask   = (rx_byte >= MASK_FULL_COUNT) ? '1 :
                       ((32'd1 << rx_byte[4:0]) - 32'd1);
  assign pt_last     = ({1'b0, cur.points_done} + 9'd1) == {1'b0, cur.hdr_count};

  // Field updates and result selection.
  always_comb begin
    st_next   = cur;
    res_valid = 1'b0;
    res       = '0;

    if (!cur.skipping) begin
      if (off == OFF_VERSION) begin
        if (cur.frame_bytes < 11'(HDR_BYTES)) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_SHORT;
          res.last       = 1'b1;
          st_next.skipping = 1'b1;
        end else if (rx_byte != expected_version) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_VERSION;
          res.last       = 1'b1;
          st_next.skipping = 1'b1;
        end
      end else if (off <= OFF_TIME_LAST) begin
        st_next.hdr_start_time[{time_lane, 3'b000} +: 8] = rx_byte;
      end else if (off <= OFF_INTVL_LAST) begin
        if (off[0]) begin
          st_next.hdr_interval[7:0] = rx_byte;
        end else begin
          st_next.hdr_interval[15:8] = rx_byte;
        end
      end else if (off == OFF_COUNT) begin
        st_next.hdr_count = rx_byte;
        if ({1'b0, rx_byte} > 9'(MAX_POINTS)) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_COUNT;
          res.last       = 1'b1;
          st_next.skipping = 1'b1;
        end else if (frame_ext >= need_mask) begin
          st_next.mask_present = 1'b1;
        end else if (frame_ext < need_points) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
          res.last       = 1'b1;
          st_next.skipping = 1'b1;
        end else begin
          st_next.hdr_mask  = dflt_mask;
          res_valid         = 1'b1;
          res.kind          = KIND_HEADER;
          res.error_code    = ERR_SHORT;
          res.start_time    = cur.hdr_start_time;
          res.interval_secs = cur.hdr_interval;
          res.point_count   = rx_byte;
          res.valid_bits    = dflt_mask;
          res.last          = (rx_byte == 8'd0);
          st_next.skipping  = (rx_byte == 8'd0);
        end
      end else if (cur.mask_present && (off < OFF_MASK_END)) begin
        st_next.hdr_mask[{off[1:0], 3'b000} +: 8] = rx_byte;
        if (off == OFF_MASK_LAST) begin
          res_valid         = 1'b1;
          res.kind          = KIND_HEADER;
          res.error_code    = ERR_SHORT;
          res.start_time    = cur.hdr_start_time;
          res.interval_secs = cur.hdr_interval;
          res.point_count   = cur.hdr_count;
          res.valid_bits    = {rx_byte, cur.hdr_mask[23:0]};
          res.last          = (cur.hdr_count == 8'd0);
          st_next.skipping  = (cur.hdr_count == 8'd0);
        end
      end else if (pos != 3'd7) begin
        st_next.point_shift[{pos, 3'b000} +: 8] = rx_byte;
      end else begin
        // Final byte of a point: the pair is complete.
        res_valid         = 1'b1;
        res.kind          = KIND_POINT;
        res.error_code    = ERR_SHORT;
        res.start_time    = cur.hdr_start_time;
        res.interval_secs = cur.hdr_interval;
        res.point_count   = cur.hdr_count;
        res.valid_bits    = cur.hdr_mask;
        res.point_index   = cur.points_done;
        res.latitude      = cur.point_shift[31:0];
        res.longitude     = {rx_byte, cur.point_shift[55:32]};
        res.last          = pt_last;
        st_next.points_done = cur.points_done + 8'd1;
        st_next.point_shift = 56'd0;
        st_next.skipping    = pt_last;
      end
    end

    // The frame ends once its latched length has been consumed.
    if (({1'b0, off} + 12'd1) >= frame_ext) begin
      st_next.byte_offset = 11'd0;
    end else begin
      st_next.byte_offset = off + 11'd1;
    end
  end

endmodule

>>> rtl/track_report_frame_parser.sv
// ----------------------------------------------------------------------------
// track_report_frame_parser
// Byte-serial parser for little-endian position-track frames. Emits a header
// result, one result per latitude/longitude pair, or one error result.
// Results are registered: each shows in the cycle after its byte transfer.
// Throughput: one byte per cycle; the single parser step and the output
// register limit it, and the input stalls only while a result is not taken.
// Reset: synchronous; clears parser state and the output valid, and sets
// expected_version to 1.
// ----------------------------------------------------------------------------
module track_report_frame_parser #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Byte input: [7:0] rx_byte, [18:8] frame_len, [23:19] zero
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,
  // Result output
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] error_code, [33:2] start_time, [49:34] interval_secs,
  // [57:50] point_count, [89:58] valid_bits, [97:90] point_index,
  // [129:98] latitude, [161:130] longitude, [167:162] zero
  output logic [167:0] m_tdata,
  // [1:0] kind
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);
  import trfp_pkg::*;

  logic [7:0] expected_version;
  state_t     st;
  state_t     st_next;
  logic       res_valid;
  result_t    res;
  result_t    res_q;
  logic       in_xfer;
  logic       cfg_write;

  // Configuration register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd1;
    end else if (cfg_write && (paddr[2] == REG_EXPECTED_VERSION)) begin
      expected_version <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_EXPECTED_VERSION) ? {24'd0, expected_version} : 32'd0;

  // Input handshake: a byte moves whenever the output register can take
  // whatever it produces.
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  trfp_step #(
    .MAX_POINTS(MAX_POINTS)
  ) u_step (
    .st               (st),
    .rx_byte          (s_tdata[7:0]),
    .frame_len        (s_tdata[18:8]),
    .expected_version (expected_version),
    .st_next          (st_next),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_xfer) begin
      st <= st_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign m_tdata = {6'd0, res_q.longitude, res_q.latitude, res_q.point_index,
                    res_q.valid_bits, res_q.point_count, res_q.interval_secs,
                    res_q.start_time, res_q.error_code};
  assign m_tuser = res_q.kind;
  assign m_tlast = res_q.last;

`ifndef NO_ASSERTIONS
  // The offset never runs past the latched frame length.
  a_offset_in_frame: assert property (@(posedge clk) disable iff (rst)
    (st.byte_offset == 11'd0) || (st.byte_offset < st.frame_bytes))
    else $error("byte offset beyond frame length");

  // Points are never emitted beyond the announced count.
  a_points_bounded: assert property (@(posedge clk) disable iff (rst)
    st.skipping || (st.points_done <= st.hdr_count))
    else $error("more points parsed than announced");

  // A point result carries an index inside the announced count.
  a_point_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res_q.kind == KIND_POINT)) |-> (res_q.point_index < res_q.point_count))
    else $error("point index out of range");

  // An error result always ends the frame and stops further results.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res_q.kind == KIND_ERROR)) |-> (res_q.last && st.skipping))
    else $error("error result without frame end");
`endif

endmodule

>>> test/track_report_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// track_report_frame_parser_tb
// Self-checking bench for the track report frame parser. Frames are built
// byte by byte and streamed into the parser. A behavioral parser in the bench
// predicts the header, point and error transfers. Every output transfer is
// compared field by field against the oldest prediction. Directed frames hit
// the length, version, count and mask corner cases. Random frames, mostly
// well formed, then run under changing stall patterns and version settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module track_report_frame_parser_tb;
  import trfp_pkg::*;

  localparam int unsigned MAX_POINTS   = 32;
  localparam int          DRAIN_CYCLES = 4;
  localparam logic [2:0]  VERSION_ADDR = 3'(4 * int'(REG_EXPECTED_VERSION));

  logic         clk = 1'b0;
  logic         rst;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid;
  logic         s_tready;
  // [7:0] rx_byte, [18:8] frame_len, [23:19] zero
  logic [23:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // [1:0] error_code, [33:2] start_time, [49:34] interval_secs,
  // [57:50] point_count, [89:58] valid_bits, [97:90] point_index,
  // [129:98] latitude, [161:130] longitude, [167:162] zero
  logic [167:0] m_tdata;
  // [1:0] kind
  logic [1:0]   m_tuser;
  logic         m_tlast;

  // Stall settings, in percent of cycles.
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 51;

  // Predicted parser state.
  logic [7:0]  cfg_version  = 8'd1;
  logic [10:0] byte_pos     = '0;
  logic [10:0] frame_total  = '0;
  logic        in_skip      = 1'b0;
  logic        has_mask     = 1'b0;
  logic [31:0] trk_time     = '0;
  logic [15:0] trk_interval = '0;
  logic [7:0]  trk_count    = '0;
  logic [31:0] trk_mask     = '0;
  logic [7:0]  pts_seen     = '0;
  logic [55:0] pt_bytes     = '0;

  result_t pending_results[$];
  result_t predicted;

  int fail_count   = 0;
  int bytes_sent   = 0;
  int frames_sent  = 0;
  int header_count = 0;
  int point_count  = 0;
  int error_count  = 0;

  track_report_frame_parser #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // An error ends the frame; the rest of its bytes are dropped.
  function automatic result_t error_result(err_t code);
    result_t res;
    res            = '0;
    res.kind       = KIND_ERROR;
    res.error_code = code;
    res.last       = 1'b1;
    in_skip        = 1'b1;
    return res;
  endfunction

  function automatic result_t header_result();
    result_t res;
    res               = '0;
    res.kind          = KIND_HEADER;
    res.start_time    = trk_time;
    res.interval_secs = trk_interval;
    res.point_count   = trk_count;
    res.valid_bits    = trk_mask;
    res.last          = (trk_count == 8'd0);
    if (res.last) begin
      in_skip = 1'b1;
    end
    return res;
  endfunction

  // Advance the predicted parser by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic [10:0] len,
                                    output result_t res);
    bit emit;
    int o;
    int pbytes;
    int rem;
    int base;
    int pos;
    emit = 1'b0;
    res  = '0;
    if (byte_pos == 11'd0) begin
      frame_total  = len;
      in_skip      = 1'b0;
      has_mask     = 1'b0;
      trk_time     = '0;
      trk_interval = '0;
      trk_count    = '0;
      trk_mask     = '0;
      pts_seen     = '0;
      pt_bytes     = '0;
    end
    o = int'(byte_pos);
    if (!in_skip) begin
      if (o == int'(OFF_VERSION)) begin
        if (frame_total < HDR_BYTES) begin
          res  = error_result(ERR_SHORT);
          emit = 1'b1;
        end else if (b != cfg_version) begin
          res  = error_result(ERR_VERSION);
          emit = 1'b1;
        end
      end else if (o <= int'(OFF_TIME_LAST)) begin
        trk_time[8*(o-1) +: 8] = b;
      end else if (o <= int'(OFF_INTVL_LAST)) begin
        trk_interval[8*(o-5) +: 8] = b;
      end else if (o == int'(OFF_COUNT)) begin
        trk_count = b;
        pbytes    = int'(b) * POINT_BYTES;
        rem       = int'(frame_total) - HDR_BYTES;
        if (int'(b) > MAX_POINTS) begin
          res  = error_result(ERR_COUNT);
          emit = 1'b1;
        end else if (rem >= MASK_BYTES + pbytes) begin
          has_mask = 1'b1;
        end else if (int'(frame_total) < HDR_BYTES + pbytes) begin
          res  = error_result(ERR_TRUNCATED);
          emit = 1'b1;
        end else begin
          trk_mask = (b >= MASK_FULL_COUNT) ? '1 : (32'd1 << b) - 32'd1;
          res      = header_result();
          emit     = 1'b1;
        end
      end else if (has_mask && o < int'(OFF_MASK_END)) begin
        trk_mask[8*(o-8) +: 8] = b;
        if (o == int'(OFF_MASK_LAST)) begin
          res  = header_result();
          emit = 1'b1;
        end
      end else begin
        // Point bytes: latitude then longitude, little endian.
        base = has_mask ? int'(OFF_MASK_END) : HDR_BYTES;
        pos  = (o - base) & 7;
        if (pos < 7) begin
          pt_bytes[8*pos +: 8] = b;
        end else begin
          res               = header_result();
          res.kind          = KIND_POINT;
          res.point_index   = pts_seen;
          res.latitude      = pt_bytes[31:0];
          res.longitude     = {b, pt_bytes[55:32]};
          res.last          = (int'(pts_seen) + 1 == int'(trk_count));
          emit              = 1'b1;
          in_skip           = res.last;
          pts_seen          = pts_seen + 8'd1;
          pt_bytes          = '0;
        end
      end
    end
    if (o + 1 >= int'(frame_total)) begin
      byte_pos = '0;
    end else begin
      byte_pos = 11'(o + 1);
    end
    return emit;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_result();
    result_t got;
    result_t want;
    got.kind          = kind_t'(m_tuser);
    got.error_code    = err_t'(m_tdata[1:0]);
    got.start_time    = m_tdata[33:2];
    got.interval_secs = m_tdata[49:34];
    got.point_count   = m_tdata[57:50];
    got.valid_bits    = m_tdata[89:58];
    got.point_index   = m_tdata[97:90];
    got.latitude      = m_tdata[129:98];
    got.longitude     = m_tdata[161:130];
    got.last          = m_tlast;
    case (got.kind)
      KIND_HEADER: header_count++;
      KIND_POINT:  point_count++;
      default:     error_count++;
    endcase
    if (pending_results.size() == 0) begin
      $display("%0t: result transfer with nothing expected: expected none, actual %h",
               $time, got);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      report_field("kind", 32'(want.kind), 32'(got.kind));
      report_field("error_code", 32'(want.error_code), 32'(got.error_code));
      report_field("start_time", want.start_time, got.start_time);
      report_field("interval_secs", 32'(want.interval_secs), 32'(got.interval_secs));
      report_field("point_count", 32'(want.point_count), 32'(got.point_count));
      report_field("valid_bits", want.valid_bits, got.valid_bits);
      report_field("point_index", 32'(want.point_index), 32'(got.point_index));
      report_field("latitude", want.latitude, got.latitude);
      report_field("longitude", want.longitude, got.longitude);
      report_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  // Output check first, then prediction for the byte taken at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        compare_result();
      end
      if (s_tvalid && s_tready) begin
        if (parse_byte(s_tdata[7:0], s_tdata[18:8], predicted)) begin
          pending_results = {pending_results, predicted};
        end
      end
    end
  end

  // Present one byte and hold it until the transfer happens.
  task automatic send_byte(input logic [7:0] b, input logic [10:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, len, b};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  // Build a frame of the given length; a mask goes in when the length has room
  // for it, and whatever the layout leaves over is filled with random bytes.
  task automatic send_frame(input logic [7:0] ver, input int count, input int len,
                            input bit noisy_len);
    logic [7:0] body[$];
    int         n;
    logic [10:0] flen;
    body = {body, ver};
    repeat (6) body = {body, 8'($urandom_range(255))};
    body = {body, 8'(count)};
    if (len >= int'(OFF_MASK_END) + POINT_BYTES * count) begin
      repeat (MASK_BYTES) body = {body, 8'($urandom_range(255))};
    end
    if (count <= MAX_POINTS) begin
      repeat (POINT_BYTES * count) body = {body, 8'($urandom_range(255))};
    end
    n = (len == 0) ? 1 : len;
    for (int i = 0; i < n; i++) begin
      flen = (i > 0 && noisy_len) ? 11'($urandom_range(2047)) : 11'(len);
      send_byte((i < body.size()) ? body[i] : 8'($urandom_range(255)), flen);
    end
    frames_sent++;
  endtask

  // Stop sending and let every outstanding result drain. The first edge lets
  // the prediction for the last byte transfer land in the queue.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] value);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= VERSION_ADDR;
    pwdata  <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    cfg_version  = value;
  endtask

  task automatic check_version_reg();
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= VERSION_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    report_field("expected_version readback", {24'b0, cfg_version}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_defaults();
    check_version_reg();
    write_version(8'($urandom_range(2, 254)));
    check_version_reg();
    write_version(8'd1);
  endtask

  // Lengths under a full header, including a zero length.
  task automatic test_short_frames();
    send_frame(cfg_version, 0, 0, 1'b0);
    send_frame(cfg_version, 0, 1, 1'b0);
    send_frame(cfg_version, 2, 7, 1'b1);
  endtask

  task automatic test_bad_version();
    send_frame(~cfg_version, 0, 8, 1'b0);
    send_frame(cfg_version ^ 8'h80, 1, 20, 1'b0);
  endtask

  task automatic test_count_limit();
    send_frame(cfg_version, MAX_POINTS + 1, 40, 1'b0);
    send_frame(cfg_version, 255, 8, 1'b0);
  endtask

  task automatic test_truncated_points();
    send_frame(cfg_version, 2, 23, 1'b0);
    send_frame(cfg_version, 1, 15, 1'b0);
    send_frame(cfg_version, MAX_POINTS, 8, 1'b0);
  endtask

  // No mask in the frame: the low count bits are set, all ones at 32 points.
  task automatic test_default_mask();
    send_frame(cfg_version, 0, 8, 1'b0);
    send_frame(cfg_version, 3, 32, 1'b0);
    send_frame(cfg_version, 1, 19, 1'b0);
    send_frame(cfg_version, MAX_POINTS, 8 + 8 * MAX_POINTS, 1'b0);
  endtask

  task automatic test_mask_present();
    send_frame(cfg_version, 0, 12, 1'b0);
    send_frame(cfg_version, 2, 28, 1'b0);
    send_frame(cfg_version, MAX_POINTS, 12 + 8 * MAX_POINTS, 1'b0);
  endtask

  // Bytes after the final result are consumed silently.
  task automatic test_trailing_bytes();
    send_frame(cfg_version, 1, 40, 1'b1);
    send_frame(cfg_version, 0, 11, 1'b1);
  endtask

  task automatic test_version_extremes();
    write_version(8'd0);
    check_version_reg();
    send_frame(8'd0, 1, 20, 1'b0);
    send_frame(8'd1, 1, 20, 1'b0);
    write_version(8'hFF);
    check_version_reg();
    send_frame(8'hFF, 2, 24, 1'b0);
    send_frame(8'd0, 2, 24, 1'b0);
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise.
  task automatic test_random_traffic(input int n_bytes);
    int start;
    int pick;
    int count;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        count = ($urandom_range(9) == 0) ? $urandom_range(5, MAX_POINTS)
                                         : $urandom_range(0, 4);
        len   = $urandom_range(1) ? 12 + 8 * count + $urandom_range(0, 6)
                                  : 8 + 8 * count + $urandom_range(0, 3);
        send_frame(cfg_version, count, len, $urandom_range(3) == 0);
      end else if (pick < 78) begin
        count = $urandom_range(1, 6);
        send_frame(cfg_version, count, $urandom_range(8, 7 + 8 * count), 1'b0);
      end else if (pick < 84) begin
        send_frame(cfg_version, $urandom_range(MAX_POINTS + 1, 255),
                   $urandom_range(8, 40), 1'b0);
      end else if (pick < 90) begin
        send_frame(cfg_version ^ 8'($urandom_range(1, 255)), $urandom_range(4),
                   $urandom_range(8, 40), 1'b0);
      end else if (pick < 96) begin
        send_frame(cfg_version, $urandom_range(4), $urandom_range(0, 7), 1'b1);
      end else begin
        send_frame(8'($urandom_range(255)), $urandom_range(255),
                   $urandom_range(0, 30), 1'b1);
      end
      if ($urandom_range(24) == 0) begin
        wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin
    #2_000_000;
    $display("[track_report_frame_parser] ERROR");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_short_frames();
    test_bad_version();
    test_count_limit();
    test_truncated_points();
    test_default_mask();
    test_mask_present();
    test_trailing_bytes();
    test_version_extremes();

    write_version(8'($urandom_range(255)));
    test_random_traffic(50);
    send_idle_pct = 51;
    recv_idle_pct = 9;
    write_version(8'd1);
    test_random_traffic(50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_version(8'($urandom_range(255)));
    test_random_traffic(50);
    wait_idle();

    // Every predicted result must have been seen on the output.
    if (pending_results.size() != 0) begin
      $display("%0t: results never delivered: expected 0 outstanding, actual %0d",
               $time, pending_results.size());
      fail_count++;
    end

    $display("Ran %0d frames (%0d bytes): %0d headers, %0d points, %0d errors checked.",
             frames_sent, bytes_sent, header_count, point_count, error_count);
    $display("Version register swept through 0, 255 and random values under stalls.");
    if (fail_count == 0) begin
      $display("[track_report_frame_parser] OK");
    end else begin
      $display("[track_report_frame_parser] ERROR");
    end
    $finish;
  end

endmodule
